/* sv/bor_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Box overlap ratio package
// Types shared by the overlap ratio pipeline and its divider stages.
// ----------------------------------------------------------------------------
package bor_pkg;

   // Outcome flags that travel alongside the division through the pipeline.
   typedef struct packed {
      logic invalid;   // a box has a non-positive width or height
      logic zero;      // the boxes do not overlap
      logic full;      // intersection covers the smaller box
   } flags_type;

endpackage
`default_nettype wire

/* sv/bor_channel_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Box overlap ratio channels
// Valid/ready channels for box pair requests and ratio responses.
// ----------------------------------------------------------------------------
interface bor_req_if #(
   parameter int COORD_BITS = 16
) ();
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] a_left;
   logic signed [COORD_BITS-1:0] a_top;
   logic signed [COORD_BITS-1:0] a_width;
   logic signed [COORD_BITS-1:0] a_height;
   logic signed [COORD_BITS-1:0] b_left;
   logic signed [COORD_BITS-1:0] b_top;
   logic signed [COORD_BITS-1:0] b_width;
   logic signed [COORD_BITS-1:0] b_height;

   modport source (
      output valid, a_left, a_top, a_width, a_height,
      output b_left, b_top, b_width, b_height,
      input  ready
   );
   modport sink (
      input  valid, a_left, a_top, a_width, a_height,
      input  b_left, b_top, b_width, b_height,
      output ready
   );
endinterface

interface bor_rsp_if #(
   parameter int FRAC_BITS = 16
) ();
   logic                 valid;
   logic                 ready;
   logic [FRAC_BITS:0]   ratio;
   logic                 invalid;

   modport source (output valid, ratio, invalid, input ready);
   modport sink (input valid, ratio, invalid, output ready);
endinterface
`default_nettype wire

/* sv/bor_div_stage.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Box overlap ratio divider stage
// One registered step of a restoring fraction divider with valid/ready flow.
// ----------------------------------------------------------------------------
module bor_div_stage #(
   parameter int AREA_BITS = 30,
   parameter int FRAC_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire logic [AREA_BITS-1:0] in_rem,
   input  wire logic [AREA_BITS-1:0] in_den,
   input  wire logic [FRAC_BITS-1:0] in_quo,
   input  wire bor_pkg::flags_type   in_flags,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output logic [AREA_BITS-1:0]      out_rem,
   output logic [AREA_BITS-1:0]      out_den,
   output logic [FRAC_BITS-1:0]      out_quo,
   output bor_pkg::flags_type        out_flags
);

   logic                 valid_ff;
   logic [AREA_BITS-1:0] rem_ff;
   logic [AREA_BITS-1:0] rem_in;
   logic [AREA_BITS-1:0] den_ff;
   logic [FRAC_BITS-1:0] quo_ff;
   logic [FRAC_BITS-1:0] quo_in;
   bor_pkg::flags_type   flags_ff;
   logic [AREA_BITS:0]   shifted;
   logic [AREA_BITS:0]   diff;
   logic                 take;

   assign in_ready = !valid_ff || out_ready;

   // The partial remainder stays below the divisor, so the doubled value
   // fits in one extra bit and the difference fits back in the area width.
   always_comb begin
      shifted = {in_rem, 1'b0};
      diff    = shifted - {1'b0, in_den};
      take    = (shifted >= {1'b0, in_den});
      rem_in  = take ? diff[AREA_BITS-1:0] : shifted[AREA_BITS-1:0];
      quo_in  = {in_quo[FRAC_BITS-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         rem_ff   <= rem_in;
         den_ff   <= in_den;
         quo_ff   <= quo_in;
         flags_ff <= in_flags;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_den   = den_ff;
   assign out_quo   = quo_ff;
   assign out_flags = flags_ff;

endmodule
`default_nettype wire

/* sv/box_overlap_ratio.sv */
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one box pair per cycle while the response side does not stall;
// every stage holds one transaction. The depth comes from five front stages
// (edges, bounds, extents, area multipliers, minimum area), one restoring
// divider stage per fraction bit and the response register.
// A stalled response backs up stage by stage; bubbles are squeezed out.
// Reset is synchronous and clears only the valid bit of each stage.
// ----------------------------------------------------------------------------
// Box overlap ratio
// Intersection area over the smaller box area, unsigned fixed point, pipelined.
// ----------------------------------------------------------------------------
module box_overlap_ratio #(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   bor_req_if.sink   req_ch,
   bor_rsp_if.source rsp_ch
);

   localparam int EdgeBits = COORD_BITS + 2;
   localparam int SizeBits = COORD_BITS - 1;
   localparam int AreaBits = 2 * SizeBits;
   localparam logic [FRAC_BITS:0] RatioOne = {1'b1, {FRAC_BITS{1'b0}}};

   // ---------------- Stage 1: box edges ----------------
   logic                       s1_valid_ff;
   logic                       s1_ready;
   logic signed [EdgeBits-1:0] s1_al_ff, s1_at_ff, s1_bl_ff, s1_bt_ff;
   logic signed [EdgeBits-1:0] s1_ar_ff, s1_ab_ff, s1_br_ff, s1_bb_ff;
   logic signed [EdgeBits-1:0] s1_al_in, s1_at_in, s1_bl_in, s1_bt_in;
   logic signed [EdgeBits-1:0] s1_aw_x, s1_ah_x, s1_bw_x, s1_bh_x;
   logic [SizeBits-1:0]        s1_aw_ff, s1_ah_ff, s1_bw_ff, s1_bh_ff;
   logic                       s1_inv_ff;
   logic                       s1_inv_in;

   // ---------------- Stage 2: intersection bounds ----------------
   logic                       s2_valid_ff;
   logic                       s2_ready;
   logic signed [EdgeBits-1:0] s2_il_ff, s2_ir_ff, s2_it_ff, s2_ib_ff;
   logic [SizeBits-1:0]        s2_aw_ff, s2_ah_ff, s2_bw_ff, s2_bh_ff;
   logic                       s2_inv_ff;

   // ---------------- Stage 3: intersection extents ----------------
   logic                       s3_valid_ff;
   logic                       s3_ready;
   logic signed [EdgeBits-1:0] s3_ew_x, s3_eh_x;
   logic [SizeBits-1:0]        s3_ew_ff, s3_eh_ff;
   logic [SizeBits-1:0]        s3_aw_ff, s3_ah_ff, s3_bw_ff, s3_bh_ff;
   logic                       s3_inv_ff;
   logic                       s3_ovl_ff;

   // ---------------- Stage 4: areas ----------------
   logic                       s4_valid_ff;
   logic                       s4_ready;
   logic [AreaBits-1:0]        s4_ia_ff, s4_aa_ff, s4_ba_ff;
   logic                       s4_inv_ff;
   logic                       s4_ovl_ff;

   // ---------------- Stage 5: smaller area and outcome flags ----------------
   logic                       s5_valid_ff;
   logic                       s5_ready;
   logic [AreaBits-1:0]        s5_ia_ff, s5_ma_ff;
   logic [AreaBits-1:0]        s5_ma_in;
   bor_pkg::flags_type         s5_flags_ff;
   bor_pkg::flags_type         s5_flags_in;

   // ---------------- Divider chain and response register ----------------
   logic                       dv_valid [FRAC_BITS+1];
   logic                       dv_ready [FRAC_BITS+1];
   logic [AreaBits-1:0]        dv_rem   [FRAC_BITS+1];
   logic [AreaBits-1:0]        dv_den   [FRAC_BITS+1];
   logic [FRAC_BITS-1:0]       dv_quo   [FRAC_BITS+1];
   bor_pkg::flags_type         dv_flags [FRAC_BITS+1];

   logic                       out_valid_ff;
   logic                       out_ready;
   logic [FRAC_BITS:0]         out_ratio_ff;
   logic [FRAC_BITS:0]         out_ratio_in;
   logic                       out_inv_ff;

   // Stage 1 -----------------------------------------------------------------
   assign s1_ready     = !s1_valid_ff || s2_ready;
   assign req_ch.ready = s1_ready;

   always_comb begin
      s1_al_in  = EdgeBits'(req_ch.a_left);
      s1_at_in  = EdgeBits'(req_ch.a_top);
      s1_bl_in  = EdgeBits'(req_ch.b_left);
      s1_bt_in  = EdgeBits'(req_ch.b_top);
      s1_aw_x   = EdgeBits'(req_ch.a_width);
      s1_ah_x   = EdgeBits'(req_ch.a_height);
      s1_bw_x   = EdgeBits'(req_ch.b_width);
      s1_bh_x   = EdgeBits'(req_ch.b_height);
      s1_inv_in = req_ch.a_width[COORD_BITS-1]  || (req_ch.a_width == '0)  ||
                  req_ch.a_height[COORD_BITS-1] || (req_ch.a_height == '0) ||
                  req_ch.b_width[COORD_BITS-1]  || (req_ch.b_width == '0)  ||
                  req_ch.b_height[COORD_BITS-1] || (req_ch.b_height == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_ch.valid;
      end
   end

   // Right and bottom edges are inclusive, hence the minus one.
   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_al_ff  <= s1_al_in;
         s1_at_ff  <= s1_at_in;
         s1_bl_ff  <= s1_bl_in;
         s1_bt_ff  <= s1_bt_in;
         s1_ar_ff  <= s1_al_in + s1_aw_x - EdgeBits'(1);
         s1_ab_ff  <= s1_at_in + s1_ah_x - EdgeBits'(1);
         s1_br_ff  <= s1_bl_in + s1_bw_x - EdgeBits'(1);
         s1_bb_ff  <= s1_bt_in + s1_bh_x - EdgeBits'(1);
         s1_aw_ff  <= req_ch.a_width[SizeBits-1:0];
         s1_ah_ff  <= req_ch.a_height[SizeBits-1:0];
         s1_bw_ff  <= req_ch.b_width[SizeBits-1:0];
         s1_bh_ff  <= req_ch.b_height[SizeBits-1:0];
         s1_inv_ff <= s1_inv_in;
      end
   end

   // Stage 2 -----------------------------------------------------------------
   assign s2_ready = !s2_valid_ff || s3_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_il_ff  <= (s1_al_ff > s1_bl_ff) ? s1_al_ff : s1_bl_ff;
         s2_ir_ff  <= (s1_ar_ff < s1_br_ff) ? s1_ar_ff : s1_br_ff;
         s2_it_ff  <= (s1_at_ff > s1_bt_ff) ? s1_at_ff : s1_bt_ff;
         s2_ib_ff  <= (s1_ab_ff < s1_bb_ff) ? s1_ab_ff : s1_bb_ff;
         s2_aw_ff  <= s1_aw_ff;
         s2_ah_ff  <= s1_ah_ff;
         s2_bw_ff  <= s1_bw_ff;
         s2_bh_ff  <= s1_bh_ff;
         s2_inv_ff <= s1_inv_ff;
      end
   end

   // Stage 3 -----------------------------------------------------------------
   assign s3_ready = !s3_valid_ff || s4_ready;

   // When the boxes overlap, each extent is at most the smaller box size,
   // which always fits the positive range of a size field.
   always_comb begin
      s3_ew_x = s2_ir_ff - s2_il_ff + EdgeBits'(1);
      s3_eh_x = s2_ib_ff - s2_it_ff + EdgeBits'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_ready) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready) begin
         s3_ew_ff  <= s3_ew_x[SizeBits-1:0];
         s3_eh_ff  <= s3_eh_x[SizeBits-1:0];
         s3_aw_ff  <= s2_aw_ff;
         s3_ah_ff  <= s2_ah_ff;
         s3_bw_ff  <= s2_bw_ff;
         s3_bh_ff  <= s2_bh_ff;
         s3_inv_ff <= s2_inv_ff;
         s3_ovl_ff <= (s2_il_ff <= s2_ir_ff) && (s2_it_ff <= s2_ib_ff);
      end
   end

   // Stage 4 -----------------------------------------------------------------
   assign s4_ready = !s4_valid_ff || s5_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (s4_ready) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s4_ready) begin
         s4_ia_ff  <= AreaBits'(s3_ew_ff) * AreaBits'(s3_eh_ff);
         s4_aa_ff  <= AreaBits'(s3_aw_ff) * AreaBits'(s3_ah_ff);
         s4_ba_ff  <= AreaBits'(s3_bw_ff) * AreaBits'(s3_bh_ff);
         s4_inv_ff <= s3_inv_ff;
         s4_ovl_ff <= s3_ovl_ff;
      end
   end

   // Stage 5 -----------------------------------------------------------------
   // Containment makes the intersection equal the smaller area, so the
   // single area compare also covers that case.
   assign s5_ready = !s5_valid_ff || dv_ready[0];

   always_comb begin
      s5_ma_in            = (s4_aa_ff < s4_ba_ff) ? s4_aa_ff : s4_ba_ff;
      s5_flags_in.invalid = s4_inv_ff;
      s5_flags_in.zero    = !s4_ovl_ff;
      s5_flags_in.full    = (s4_ia_ff >= s5_ma_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (s5_ready) begin
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s5_ready) begin
         s5_ia_ff    <= s4_ia_ff;
         s5_ma_ff    <= s5_ma_in;
         s5_flags_ff <= s5_flags_in;
      end
   end

   // Divider chain: one quotient bit per stage ---------------------------------
   assign dv_valid[0] = s5_valid_ff;
   assign dv_rem[0]   = s5_ia_ff;
   assign dv_den[0]   = s5_ma_ff;
   assign dv_quo[0]   = '0;
   assign dv_flags[0] = s5_flags_ff;
   assign dv_ready[FRAC_BITS] = out_ready;

   for (genvar gi = 0; gi < FRAC_BITS; gi++) begin : g_div
      bor_div_stage #(
         .AREA_BITS (AreaBits),
         .FRAC_BITS (FRAC_BITS)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (dv_valid[gi]),
         .in_ready  (dv_ready[gi]),
         .in_rem    (dv_rem[gi]),
         .in_den    (dv_den[gi]),
         .in_quo    (dv_quo[gi]),
         .in_flags  (dv_flags[gi]),
         .out_valid (dv_valid[gi+1]),
         .out_ready (dv_ready[gi+1]),
         .out_rem   (dv_rem[gi+1]),
         .out_den   (dv_den[gi+1]),
         .out_quo   (dv_quo[gi+1]),
         .out_flags (dv_flags[gi+1])
      );
   end

   // Response register ---------------------------------------------------------
   assign out_ready = !out_valid_ff || rsp_ch.ready;

   always_comb begin
      if (dv_flags[FRAC_BITS].invalid || dv_flags[FRAC_BITS].zero) begin
         out_ratio_in = '0;
      end else if (dv_flags[FRAC_BITS].full) begin
         out_ratio_in = RatioOne;
      end else begin
         out_ratio_in = {1'b0, dv_quo[FRAC_BITS]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= dv_valid[FRAC_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         out_ratio_ff <= out_ratio_in;
         out_inv_ff   <= dv_flags[FRAC_BITS].invalid;
      end
   end

   assign rsp_ch.valid   = out_valid_ff;
   assign rsp_ch.ratio   = out_ratio_ff;
   assign rsp_ch.invalid = out_inv_ff;

   // Assertions ---------------------------------------------------------------
   a_invalid_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.invalid |-> rsp_ch.ratio == '0)
      else $error("invalid response carries a nonzero ratio");

   a_ratio_max : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.ratio[FRAC_BITS] |-> rsp_ch.ratio[FRAC_BITS-1:0] == '0)
      else $error("ratio exceeds 1.0");

   a_stall_only_when_full : assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> rsp_ch.valid && !rsp_ch.ready)
      else $error("request side stalled while response side can move");

   a_out_load : assert property (@(posedge clock) disable iff (reset)
      out_ready && dv_valid[FRAC_BITS] |=> rsp_ch.valid)
      else $error("finished transaction lost before the response register");

endmodule
`default_nettype wire

/* tb/sv/box_overlap_ratio_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Box overlap ratio testbench
// Drives box pairs through the valid/ready request channel under varying
// source and sink stalls. A local predictor computes the intersection over the
// smaller area for every accepted request. Each response is checked in order
// against it.
// ----------------------------------------------------------------------------
module box_overlap_ratio_tb;

   localparam int COORD_BITS  = 16;
   localparam int FRAC_BITS   = 16;
   localparam int LATENCY     = FRAC_BITS + 6;
   localparam int CYCLE_LIMIT = 200000;
   localparam logic [FRAC_BITS:0] RATIO_ONE = {1'b1, {FRAC_BITS{1'b0}}};

   typedef struct {
      shortint a_left;
      shortint a_top;
      shortint a_width;
      shortint a_height;
      shortint b_left;
      shortint b_top;
      shortint b_width;
      shortint b_height;
   } box_pair_type;

   typedef struct {
      logic [FRAC_BITS:0] ratio;
      logic               invalid;
   } overlap_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bor_req_if #(.COORD_BITS(COORD_BITS)) req_ch ();
   bor_rsp_if #(.FRAC_BITS(FRAC_BITS))   rsp_ch ();

   box_overlap_ratio #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   always #2 clock = ~clock;

   box_pair_type pending_pairs[$];
   overlap_type  expected_overlaps[$];
   int unsigned  source_idle_pct = 0;
   int unsigned  sink_idle_pct   = 0;
   int unsigned  mismatch_count  = 0;
   int unsigned  cycle_count     = 0;
   logic         req_fired       = 1'b0;

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   // Edges are inclusive, so a box covers left .. left + width - 1.
   function automatic overlap_type predict_overlap(input box_pair_type p);
      overlap_type r;
      longint   a_right, a_bottom, b_right, b_bottom;
      longint   x_lo, x_hi, y_lo, y_hi;
      longint   inter_area, min_area;
      bit       contained;
      r.ratio   = '0;
      r.invalid = 1'b0;
      if (p.a_width <= 0 || p.a_height <= 0 || p.b_width <= 0 || p.b_height <= 0) begin
         r.invalid = 1'b1;
      end else begin
         a_right  = longint'(p.a_left) + p.a_width - 1;
         a_bottom = longint'(p.a_top) + p.a_height - 1;
         b_right  = longint'(p.b_left) + p.b_width - 1;
         b_bottom = longint'(p.b_top) + p.b_height - 1;
         contained = (p.a_left <= p.b_left && b_right <= a_right &&
                      p.a_top <= p.b_top && b_bottom <= a_bottom) ||
                     (p.b_left <= p.a_left && a_right <= b_right &&
                      p.b_top <= p.a_top && a_bottom <= b_bottom);
         x_lo = (p.a_left > p.b_left) ? p.a_left : p.b_left;
         x_hi = (a_right < b_right) ? a_right : b_right;
         y_lo = (p.a_top > p.b_top) ? p.a_top : p.b_top;
         y_hi = (a_bottom < b_bottom) ? a_bottom : b_bottom;
         if (contained) begin
            r.ratio = RATIO_ONE;
         end else if (x_lo <= x_hi && y_lo <= y_hi) begin
            inter_area = (x_hi - x_lo + 1) * (y_hi - y_lo + 1);
            min_area   = longint'(p.a_width) * p.a_height;
            if (longint'(p.b_width) * p.b_height < min_area)
               min_area = longint'(p.b_width) * p.b_height;
            if (inter_area >= min_area)
               r.ratio = RATIO_ONE;
            else
               r.ratio = (FRAC_BITS + 1)'((inter_area << FRAC_BITS) / min_area);
         end
      end
      return r;
   endfunction

   task automatic add_pair(input int al, at, aw, ah, bl, bt, bw, bh);
      box_pair_type p;
      p.a_left   = shortint'(al);
      p.a_top    = shortint'(at);
      p.a_width  = shortint'(aw);
      p.a_height = shortint'(ah);
      p.b_left   = shortint'(bl);
      p.b_top    = shortint'(bt);
      p.b_width  = shortint'(bw);
      p.b_height = shortint'(bh);
      pending_pairs.push_back(p);
   endtask

   function automatic int pick_size();
      if ($urandom_range(9) == 0)
         return $urandom_range(32767, 1);
      return $urandom_range(64, 1);
   endfunction

   // Mostly nearby boxes of modest size so that partial overlaps dominate;
   // the rest are nested boxes, raw bit patterns and invalid dimensions.
   function automatic box_pair_type random_pair();
      box_pair_type p;
      int unsigned  pick;
      pick       = $urandom_range(99);
      p.a_left   = shortint'($urandom);
      p.a_top    = shortint'($urandom);
      p.a_width  = shortint'(pick_size());
      p.a_height = shortint'(pick_size());
      p.b_width  = shortint'(pick_size());
      p.b_height = shortint'(pick_size());
      p.b_left   = shortint'(int'(p.a_left) + int'($urandom_range(160)) - 80);
      p.b_top    = shortint'(int'(p.a_top) + int'($urandom_range(160)) - 80);
      if (pick >= 60 && pick < 72) begin
         p.b_width  = shortint'($urandom_range(p.a_width, 1));
         p.b_height = shortint'($urandom_range(p.a_height, 1));
         p.b_left   = shortint'(int'(p.a_left) + $urandom_range(p.a_width - p.b_width));
         p.b_top    = shortint'(int'(p.a_top) + $urandom_range(p.a_height - p.b_height));
      end else if (pick >= 72 && pick < 88) begin
         p.a_left   = shortint'($urandom);
         p.a_top    = shortint'($urandom);
         p.a_width  = shortint'($urandom);
         p.a_height = shortint'($urandom);
         p.b_left   = shortint'($urandom);
         p.b_top    = shortint'($urandom);
         p.b_width  = shortint'($urandom);
         p.b_height = shortint'($urandom);
      end else if (pick >= 88) begin
         case ($urandom_range(3))
            0: p.a_width  = shortint'(-int'($urandom_range(32768)));
            1: p.a_height = shortint'(-int'($urandom_range(32768)));
            2: p.b_width  = shortint'(-int'($urandom_range(32768)));
            default: p.b_height = shortint'(-int'($urandom_range(32768)));
         endcase
      end
      return p;
   endfunction

   // Request driver and response stall generator; inputs move on the falling edge.
   always @(negedge clock) begin
      box_pair_type p;
      if (reset) begin
         req_ch.valid <= 1'b0;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
         if (!req_ch.valid || req_fired) begin
            if (pending_pairs.size() != 0 && $urandom_range(99) >= source_idle_pct) begin
               p = pending_pairs.pop_front();
               req_ch.a_left   <= p.a_left;
               req_ch.a_top    <= p.a_top;
               req_ch.a_width  <= p.a_width;
               req_ch.a_height <= p.a_height;
               req_ch.b_left   <= p.b_left;
               req_ch.b_top    <= p.b_top;
               req_ch.b_width  <= p.b_width;
               req_ch.b_height <= p.b_height;
               req_ch.valid    <= 1'b1;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: predicts on each request transaction and checks each response.
   always @(posedge clock) begin
      box_pair_type p;
      overlap_type  want;
      req_fired <= req_ch.valid && req_ch.ready && !reset;
      if (!reset && req_ch.valid && req_ch.ready) begin
         p.a_left   = req_ch.a_left;
         p.a_top    = req_ch.a_top;
         p.a_width  = req_ch.a_width;
         p.a_height = req_ch.a_height;
         p.b_left   = req_ch.b_left;
         p.b_top    = req_ch.b_top;
         p.b_width  = req_ch.b_width;
         p.b_height = req_ch.b_height;
         expected_overlaps.push_back(predict_overlap(p));
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_overlaps.size() == 0) begin
            report_mismatch($sformatf("unexpected response ratio=%h invalid=%b",
                                      rsp_ch.ratio, rsp_ch.invalid));
         end else begin
            want = expected_overlaps.pop_front();
            if (rsp_ch.ratio !== want.ratio)
               report_mismatch($sformatf("ratio %h, expected %h",
                                         rsp_ch.ratio, want.ratio));
            if (rsp_ch.invalid !== want.invalid)
               report_mismatch($sformatf("invalid %b, expected %b",
                                         rsp_ch.invalid, want.invalid));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      req_ch.valid    = 1'b0;
      req_ch.a_left   = '0;
      req_ch.a_top    = '0;
      req_ch.a_width  = '0;
      req_ch.a_height = '0;
      req_ch.b_left   = '0;
      req_ch.b_top    = '0;
      req_ch.b_width  = '0;
      req_ch.b_height = '0;
      rsp_ch.ready    = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               source_idle_pct = 30;
               sink_idle_pct   = 88;
            end
            1: begin
               source_idle_pct = 88;
               sink_idle_pct   = 30;
            end
            default: begin
               source_idle_pct = 0;
               sink_idle_pct   = 0;
            end
         endcase
         if (phase == 0) begin
            add_pair(0, 0, 10, 10, 0, 0, 10, 10);            // identical boxes
            add_pair(0, 0, 10, 10, 2, 3, 4, 5);              // second nested in first
            add_pair(5, 5, 3, 3, 0, 0, 20, 20);              // first nested in second
            add_pair(0, 0, 10, 10, 10, 0, 5, 5);             // abutting, no shared column
            add_pair(0, 0, 10, 10, 9, 0, 5, 5);              // one shared column
            add_pair(0, 0, 10, 10, 0, 10, 10, 10);           // abutting vertically
            add_pair(0, 0, 10, 10, 5, 5, 10, 10);            // diagonal overlap
            add_pair(0, 0, 1000, 1000, 1, 0, 1000, 1000);    // ratio just below one
            add_pair(0, 4, 20, 2, 9, 0, 2, 20);              // crossing bars
            add_pair(3, 3, 1, 1, 3, 3, 1, 1);                // single pixels
            add_pair(0, 0, 50, 50, 49, 49, 1, 1);            // pixel in the far corner
            add_pair(0, 0, 0, 10, 0, 0, 10, 10);             // zero widths and heights
            add_pair(0, 0, 10, 0, 0, 0, 10, 10);
            add_pair(0, 0, 10, 10, 0, 0, 0, 10);
            add_pair(0, 0, 10, 10, 0, 0, 10, 0);
            add_pair(0, 0, -1, 10, 0, 0, 10, 10);
            add_pair(0, 0, 10, 10, 0, 0, 10, -32768);
            add_pair(-32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767);
            add_pair(-32768, -32768, 32767, 32767, 0, 0, 32767, 32767);
            add_pair(-1, -1, 32767, 32767, -32768, -32768, 32767, 32767);
            add_pair(32767, 32767, 32767, 32767, 32767, -32768, 32767, 32767);
            add_pair(-32768, 32767, 1, 32767, -32768, 32767, 32767, 1);
         end
         for (int n = 0; n < 150; n++)
            pending_pairs.push_back(random_pair());
         while (pending_pairs.size() != 0 || req_ch.valid)
            @(posedge clock);
      end

      while (expected_overlaps.size() != 0)
         @(posedge clock);
      repeat (2 * LATENCY) @(posedge clock);
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

/* box_overlap_ratio.f */
sv/bor_pkg.sv
sv/bor_channel_if.sv
sv/bor_div_stage.sv
sv/box_overlap_ratio.sv
tb/sv/box_overlap_ratio_tb.sv
